/* hdl/sha_pkg.sv */
// Package for the strip history autorange block.
// Holds sizes, register indexes, controller states and the command/status structs.
`default_nettype none
package sha_pkg;

    localparam int HISTORY_DEPTH = 1024;
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int ACC_W = 40;

    typedef enum logic [2:0] {
        REG_UPPER_FLOOR   = 3'd0,
        REG_UPPER_CEILING = 3'd1,
        REG_LOWER_FLOOR   = 3'd2,
        REG_LOWER_CEILING = 3'd3,
        REG_VIEW_POINTS   = 3'd4,
        REG_AUTORANGE_ON  = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INIT,
        ST_T125,
        ST_RND,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic store;
        logic drop;
        logic side;
        logic bnd_init;
        logic t125_step;
        logic rnd_init;
        logic rnd_step;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic drop_zero;
        logic auto_on;
        logic scan_busy;
        logic direct;
        logic acc_le_mi;
        logic step_ok;
    } sts_t;

endpackage
`default_nettype wire

/* hdl/sha_if.sv */
// Channel interfaces for the strip history autorange block.
// Sample channel and result channel, valid/ready handshake.
`default_nettype none
interface sha_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface sha_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] upper_bound;
    logic signed [31:0] lower_bound;
    logic signed [31:0] window_min;
    logic signed [31:0] window_max;
    logic [1:0]         bounds_changed;
    modport source (output valid, output upper_bound, output lower_bound,
                    output window_min, output window_max, output bounds_changed,
                    input ready);
    modport sink (input valid, input upper_bound, input lower_bound,
                  input window_min, input window_max, input bounds_changed,
                  output ready);
endinterface
`default_nettype wire

/* hdl/strip_history_autorange.sv */
// Top level of the strip history autorange block.
// Depends on sha_pkg, sha_if, sha_ctrl and sha_dp.
//
// Samples enter on sample_ch and results leave on result_ch. The first two
// samples after reset are dropped with no result. A stored sample with
// autorange off offers its result in the cycle after it is accepted. With
// autorange on the window scan covers the newest n samples,
// n = min(samples stored, view_points), paced by the single read port of the
// history memory, followed by two bound roundings on the shared iterative
// decade/power-of-two unit, then the result. One sample is in work at a time;
// configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while no sample is in work, as the block does not enforce it.
`default_nettype none
module strip_history_autorange (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    sha_sample_if.sink       sample_ch,
    sha_result_if.source     result_ch
);

    sha_pkg::cmd_t cmd;
    sha_pkg::sts_t sts;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sha_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (sample_ch.sample),
        .cmd            (cmd),
        .sts            (sts),
        .upper_bound    (result_ch.upper_bound),
        .lower_bound    (result_ch.lower_bound),
        .window_min     (result_ch.window_min),
        .window_max     (result_ch.window_max),
        .bounds_changed (result_ch.bounds_changed)
    );

endmodule
`default_nettype wire

/* hdl/sha_ctrl.sv */
// Controller state machine for the strip history autorange block.
// Depends on sha_pkg; drives commands into sha_dp and reads its status.
`default_nettype none
module sha_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire sha_pkg::sts_t sts,
    output sha_pkg::cmd_t    cmd
);

    sha_pkg::state_t state_reg, state_next;
    logic            side_reg, side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        cmd        = '0;
        cmd.side   = side_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.drop_zero)
                    begin
                        cmd.store  = 1'b1;
                        state_next = sts.auto_on ? sha_pkg::ST_SCAN : sha_pkg::ST_OUT;
                    end
                    else
                    begin
                        cmd.drop = 1'b1;
                    end
                end
            end
            sha_pkg::ST_SCAN:
            begin
                if (!sts.scan_busy)
                begin
                    side_next  = 1'b0;
                    state_next = sha_pkg::ST_INIT;
                end
            end
            sha_pkg::ST_INIT:
            begin
                cmd.bnd_init = 1'b1;
                state_next   = sts.direct ? sha_pkg::ST_FIN : sha_pkg::ST_T125;
            end
            sha_pkg::ST_T125:
            begin
                if (sts.acc_le_mi)
                begin
                    cmd.t125_step = 1'b1;
                end
                else
                begin
                    cmd.rnd_init = 1'b1;
                    state_next   = sha_pkg::ST_RND;
                end
            end
            sha_pkg::ST_RND:
            begin
                if (sts.step_ok)
                begin
                    cmd.rnd_step = 1'b1;
                end
                else
                begin
                    state_next = sha_pkg::ST_FIN;
                end
            end
            sha_pkg::ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = sha_pkg::ST_INIT;
                end
                else
                begin
                    state_next = sha_pkg::ST_OUT;
                end
            end
            sha_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input and output handshakes both open");
    a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == sha_pkg::ST_FIN
                              || $past(state_reg) == sha_pkg::ST_IDLE))
        else $error("result offered without completion");
    a_fin_side: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_FIN && !side_reg) |=> state_reg == sha_pkg::ST_INIT)
        else $error("lower bound skipped");
`endif

endmodule
`default_nettype wire

/* hdl/sha_dp.sv */
// Datapath for the strip history autorange block: history memory, window scan,
// configuration registers and the iterative bound rounding unit. Depends on sha_pkg.
`default_nettype none
module sha_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic signed [31:0] sample,
    input  wire sha_pkg::cmd_t      cmd,
    output sha_pkg::sts_t           sts,
    output logic signed [31:0]      upper_bound,
    output logic signed [31:0]      lower_bound,
    output logic signed [31:0]      window_min,
    output logic signed [31:0]      window_max,
    output logic [1:0]              bounds_changed
);

    localparam int IW = sha_pkg::IDX_W;
    localparam int CW = sha_pkg::CNT_W;
    localparam int AW = sha_pkg::ACC_W;
    localparam logic [IW-1:0] IDX_LAST = IW'(sha_pkg::HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(sha_pkg::HISTORY_DEPTH);

    logic signed [31:0] ring [sha_pkg::HISTORY_DEPTH];

    logic signed [31:0] upper_floor_reg, upper_ceiling_reg;
    logic signed [31:0] lower_floor_reg, lower_ceiling_reg;
    logic [15:0]        view_reg;
    logic               auto_reg;

    logic [IW-1:0]      idx_reg, ptr_reg;
    logic [CW-1:0]      count_reg, rem_reg;
    logic [1:0]         drop_reg, changed_reg;
    logic               rd_vld_reg, flag_reg;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] upper_reg, lower_reg, min_reg, max_reg;
    logic [AW-1:0]      acc_reg;

    logic [IW-1:0]      idx_next, ptr_dec;
    logic [CW-1:0]      count_next, win_n;
    logic               rd_en;

    assign idx_next   = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign ptr_dec    = (ptr_reg == '0) ? IDX_LAST : ptr_reg - 1'b1;
    assign count_next = (count_reg == CNT_FULL) ? count_reg : count_reg + 1'b1;
    assign win_n      = ({1'b0, view_reg} < 17'(count_next)) ? CW'(view_reg) : count_next;
    assign rd_en      = (rem_reg != '0);

    // history memory
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            ring[idx_next] <= sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring[ptr_reg];
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_floor_reg   <= 32'sd1;
            upper_ceiling_reg <= 32'sh7fffffff;
            lower_floor_reg   <= 32'sh80000000;
            lower_ceiling_reg <= 32'sd0;
            view_reg          <= 16'd1024;
            auto_reg          <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sha_pkg::REG_UPPER_FLOOR:   upper_floor_reg   <= cfg_data;
                sha_pkg::REG_UPPER_CEILING: upper_ceiling_reg <= cfg_data;
                sha_pkg::REG_LOWER_FLOOR:   lower_floor_reg   <= cfg_data;
                sha_pkg::REG_LOWER_CEILING: lower_ceiling_reg <= cfg_data;
                sha_pkg::REG_VIEW_POINTS:   view_reg          <= cfg_data[15:0];
                sha_pkg::REG_AUTORANGE_ON:  auto_reg          <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // bound selection and rounding arithmetic
    logic               side;
    logic signed [31:0] lo, hi, inner, outer, v;
    logic [31:0]        m, mi;
    logic               toward, beyond_in, beyond_out, straddle;
    logic signed [31:0] dval;
    logic [AW-1:0]      acc10, acc2, acc5, step_val, m_w, mi_w, r;
    logic signed [AW:0] bs, outer_w;
    logic signed [31:0] bnew;

    always_comb
    begin
        side       = cmd.side;
        lo         = side ? lower_floor_reg : upper_floor_reg;
        hi         = side ? lower_ceiling_reg : upper_ceiling_reg;
        inner      = side ? hi : lo;
        outer      = side ? lo : hi;
        v          = side ? min_reg : max_reg;
        m          = v[31] ? (~v + 32'd1) : v;
        mi         = inner[31] ? (~inner + 32'd1) : inner;
        m_w        = AW'(m);
        mi_w       = AW'(mi);
        toward     = side != v[31];
        beyond_in  = side ? (v >= inner) : (v <= inner);
        beyond_out = side ? (v <= outer) : (v >= outer);
        straddle   = (lo < 0) && (hi > 0);
        if (beyond_in)
            dval = inner;
        else if (beyond_out)
            dval = outer;
        else if (straddle)
            dval = v;
        else
            dval = 32'sd0;
        acc10    = (acc_reg << 3) + (acc_reg << 1);
        acc2     = acc_reg << 1;
        acc5     = (acc_reg << 2) + acc_reg;
        step_val = flag_reg ? acc10 : acc2;
        if (flag_reg)
        begin
            if (m_w == acc_reg)
                r = acc_reg;
            else if (m_w < acc2)
                r = toward ? acc_reg : acc2;
            else if (m_w == acc2)
                r = acc2;
            else if (m_w < acc5)
                r = toward ? acc2 : acc5;
            else if (m_w == acc5)
                r = acc5;
            else
                r = toward ? acc5 : acc10;
        end
        else
        begin
            r = ((acc_reg != m_w) && !toward) ? acc2 : acc_reg;
        end
        bs      = v[31] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        outer_w = (AW+1)'(outer);
        if (sts.direct)
            bnew = dval;
        else if (side ? (bs <= outer_w) : (bs >= outer_w))
            bnew = outer;
        else
            bnew = bs[31:0];
    end

    always_comb
    begin
        sts.drop_zero = (drop_reg == 2'd0);
        sts.auto_on   = auto_reg;
        sts.scan_busy = rd_en || rd_vld_reg;
        sts.direct    = beyond_in || beyond_out || straddle || (v == 32'sd0);
        sts.acc_le_mi = (acc_reg <= mi_w);
        sts.step_ok   = (step_val <= m_w);
    end

    // control and result state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            ptr_reg     <= '0;
            count_reg   <= '0;
            rem_reg     <= '0;
            drop_reg    <= 2'd2;
            changed_reg <= 2'd0;
            rd_vld_reg  <= 1'b0;
            flag_reg    <= 1'b0;
            acc_reg     <= '0;
            upper_reg   <= 32'sd1;
            lower_reg   <= 32'sd0;
            min_reg     <= 32'sd0;
            max_reg     <= 32'sd0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            if (cmd.drop)
            begin
                drop_reg <= drop_reg - 2'd1;
            end
            if (cmd.store)
            begin
                idx_reg     <= idx_next;
                count_reg   <= count_next;
                changed_reg <= 2'd0;
                ptr_reg     <= (idx_next == '0) ? IDX_LAST : idx_next - 1'b1;
                if (auto_reg)
                begin
                    min_reg <= sample;
                    max_reg <= sample;
                    rem_reg <= (win_n > CW'(1)) ? win_n - 1'b1 : '0;
                end
            end
            else if (rd_en)
            begin
                ptr_reg <= ptr_dec;
                rem_reg <= rem_reg - 1'b1;
            end
            if (rd_vld_reg)
            begin
                if (rd_data_reg < min_reg)
                    min_reg <= rd_data_reg;
                if (rd_data_reg > max_reg)
                    max_reg <= rd_data_reg;
            end
            if (cmd.bnd_init)
            begin
                acc_reg  <= AW'(1);
                flag_reg <= 1'b0;
            end
            if (cmd.t125_step)
            begin
                if (mi_w == acc_reg || mi_w == acc2 || mi_w == acc5)
                    flag_reg <= 1'b1;
                acc_reg <= acc10;
            end
            if (cmd.rnd_init)
            begin
                acc_reg <= AW'(1);
            end
            if (cmd.rnd_step)
            begin
                acc_reg <= step_val;
            end
            if (cmd.fin)
            begin
                if (side)
                begin
                    if (bnew != lower_reg)
                    begin
                        lower_reg   <= bnew;
                        changed_reg <= changed_reg + 2'd1;
                    end
                end
                else if (bnew != upper_reg)
                begin
                    upper_reg   <= bnew;
                    changed_reg <= changed_reg + 2'd1;
                end
            end
        end
    end

    assign upper_bound    = upper_reg;
    assign lower_bound    = lower_reg;
    assign window_min     = min_reg;
    assign window_max     = max_reg;
    assign bounds_changed = changed_reg;

`ifndef ASSERT_OFF
    a_changed_range: assert property (@(posedge clk) disable iff (!rst_n)
        changed_reg != 2'd3)
        else $error("bound change count out of range");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("stored count beyond depth");
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(rem_reg) != '0)
        else $error("history read without pending scan");
    a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.store && auto_reg) |-> min_reg <= max_reg)
        else $error("window minimum above maximum");
`endif

endmodule
`default_nettype wire
